// File: hw/rtl/psfrl_pkg.sv
// shared constants and types for the per-source flood rate limiter
`timescale 1ns / 1ps
package psfrl_pkg;
   localparam int ENTRIES = 64;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int REMOVED_W = 7;
   localparam int ADDR_W = 32;
   localparam int TIME_W = 40;
   localparam int LIMIT_W = 6;
   localparam int WIN_W = 32;
   localparam int PADDR_W = 4;

   localparam logic [PADDR_W-1:0] REG_ACTION_LIMIT = 4'h0;
   localparam logic [PADDR_W-1:0] REG_FAST_WINDOW = 4'h4;
   localparam logic [PADDR_W-1:0] REG_SLOW_WINDOW = 4'h8;

   localparam logic CMD_ACTION = 1'b0;
   localparam logic CMD_SWEEP = 1'b1;

   localparam logic [1:0] V_ALLOW = 2'd0;
   localparam logic [1:0] V_DENY = 2'd1;
   localparam logic [1:0] V_BAN = 2'd2;
   localparam logic [1:0] V_CLOSE = 2'd3;

   localparam logic [REMOVED_W-1:0] REMOVED_MAX = 7'd127;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request
      logic clear_scan; // reset scan index and search results
      logic scan;       // issue read of current index
      logic eval;       // evaluate returned entry
      logic commit;     // write result to table
      logic finish;     // present result
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic is_sweep;
      logic privileged;
      logic scan_last;
   } stat_type;
endpackage

// File: hw/rtl/psfrl_ctrl.sv
// controller state machine sequencing lookup, sweep and result handoff
`timescale 1ns / 1ps
module psfrl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  psfrl_pkg::stat_type  stat,
   output psfrl_pkg::ctrl_type  ctrl
);
   typedef enum logic [2:0] {
      S_IDLE, S_START, S_SCAN, S_DRAIN, S_EVAL, S_COMMIT, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ctrl = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            ctrl.clear_scan = 1'b1;
            state_in = (!stat.is_sweep && stat.privileged) ? S_OUT : S_SCAN;
         end
         S_SCAN: begin
            ctrl.scan = 1'b1;
            ctrl.eval = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            ctrl.eval = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            ctrl.commit = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

// File: hw/rtl/psfrl_datapath.sv
// table storage, scan logic, rate judgment and result registers
`timescale 1ns / 1ps
module psfrl_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  psfrl_pkg::ctrl_type                 ctrl,
   output psfrl_pkg::stat_type                 stat,
   input  logic                                req_command,
   input  logic [psfrl_pkg::ADDR_W-1:0]        req_client_ip,
   input  logic [psfrl_pkg::TIME_W-1:0]        req_now_ms,
   input  logic                                req_privileged,
   input  logic [psfrl_pkg::WIN_W-1:0]         req_idle_ms,
   input  logic [psfrl_pkg::LIMIT_W-1:0]       action_limit,
   input  logic [psfrl_pkg::WIN_W-1:0]         fast_window_ms,
   input  logic [psfrl_pkg::WIN_W-1:0]         slow_window_ms,
   output logic [1:0]                          rsp_verdict,
   output logic                                rsp_table_full,
   output logic [psfrl_pkg::REMOVED_W-1:0]     rsp_removed_count
);
   localparam int IW = psfrl_pkg::IDX_W;
   localparam int TW = psfrl_pkg::TIME_W;
   localparam int DW = psfrl_pkg::ADDR_W + 2 * TW + psfrl_pkg::LIMIT_W + 1;

   logic                                 valid_ff [psfrl_pkg::ENTRIES];
   logic [DW-1:0]                        mem [psfrl_pkg::ENTRIES];

   logic                                 cmd_ff;
   logic [psfrl_pkg::ADDR_W-1:0]         ip_ff;
   logic [TW-1:0]                        now_ff;
   logic                                 priv_ff;
   logic [psfrl_pkg::WIN_W-1:0]          idle_ff;

   logic [psfrl_pkg::CNT_W-1:0]          idx_ff;
   logic [IW-1:0]                        rd_idx_ff;
   logic                                 rd_act_ff;
   logic [DW-1:0]                        rd_data_ff;
   logic                                 rd_valid_ff;

   logic                                 hit_ff, free_found_ff;
   logic [IW-1:0]                        hit_idx_ff, free_idx_ff;
   logic [DW-1:0]                        hit_data_ff;
   logic [psfrl_pkg::REMOVED_W-1:0]      removed_ff;

   logic [TW-1:0]                        new_last_ff, new_el_ff, new_el_in;
   logic [psfrl_pkg::LIMIT_W-1:0]        new_cnt_ff, new_cnt_in;
   logic                                 new_dis_ff, new_dis_in;
   logic [1:0]                           verdict_ff, verdict_in;
   logic                                 full_ff, full_in;

   logic [1:0]                           rsp_verdict_ff;
   logic                                 rsp_full_ff;
   logic [psfrl_pkg::REMOVED_W-1:0]      rsp_removed_ff;

   logic [psfrl_pkg::ADDR_W-1:0]         e_addr;
   logic [TW-1:0]                        e_last;
   logic [TW:0]                          idle_sum;
   logic                                 expired;

   logic [TW-1:0]                        h_last, h_el;
   logic [psfrl_pkg::LIMIT_W-1:0]        h_cnt;
   logic                                 h_dis;
   logic [TW-1:0]                        delta;
   logic [TW:0]                          el_sum;
   logic [TW-1:0]                        el_sat;
   logic [psfrl_pkg::LIMIT_W-1:0]        cnt_inc;

   assign e_addr = rd_data_ff[DW-1 -: psfrl_pkg::ADDR_W];
   assign e_last = rd_data_ff[DW-psfrl_pkg::ADDR_W-1 -: TW];
   assign idle_sum = {1'b0, e_last} + {{(TW + 1 - psfrl_pkg::WIN_W){1'b0}}, idle_ff};
   assign expired = idle_sum < {1'b0, now_ff};

   assign {h_last, h_el, h_cnt, h_dis} = hit_data_ff[DW-psfrl_pkg::ADDR_W-1:0];
   assign delta = (now_ff >= h_last) ? (now_ff - h_last) : '0;
   assign el_sum = {1'b0, h_el} + {1'b0, delta};
   assign el_sat = el_sum[TW] ? {TW{1'b1}} : el_sum[TW-1:0];
   assign cnt_inc = (h_cnt == {psfrl_pkg::LIMIT_W{1'b1}}) ? h_cnt
                    : h_cnt + psfrl_pkg::LIMIT_W'(1);

   assign stat.is_sweep = cmd_ff;
   assign stat.privileged = priv_ff;
   assign stat.scan_last = (idx_ff == psfrl_pkg::CNT_W'(psfrl_pkg::ENTRIES - 1));

   // rate judgment
   always_comb begin
      new_el_in = el_sat;
      new_cnt_in = cnt_inc;
      new_dis_in = h_dis;
      full_in = 1'b0;
      verdict_in = psfrl_pkg::V_ALLOW;
      if (cmd_ff) begin
         verdict_in = psfrl_pkg::V_ALLOW;
      end else if (!hit_ff) begin
         verdict_in = psfrl_pkg::V_ALLOW;
         full_in = !free_found_ff;
         new_el_in = '0;
         new_cnt_in = '0;
         new_dis_in = 1'b0;
      end else if (h_dis) begin
         verdict_in = psfrl_pkg::V_DENY;
      end else if (cnt_inc < action_limit) begin
         verdict_in = psfrl_pkg::V_ALLOW;
      end else begin
         new_cnt_in = '0;
         new_el_in = '0;
         if (el_sat < {{(TW - psfrl_pkg::WIN_W){1'b0}}, fast_window_ms}) begin
            verdict_in = psfrl_pkg::V_BAN;
            new_dis_in = 1'b1;
         end else if (el_sat < {{(TW - psfrl_pkg::WIN_W){1'b0}}, slow_window_ms}) begin
            verdict_in = psfrl_pkg::V_CLOSE;
         end else begin
            verdict_in = psfrl_pkg::V_ALLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_command;
         ip_ff <= req_client_ip;
         now_ff <= req_now_ms;
         priv_ff <= req_privileged;
         idle_ff <= req_idle_ms;
      end
      if (ctrl.scan) begin
         rd_data_ff <= mem[idx_ff[IW-1:0]];
         rd_idx_ff <= idx_ff[IW-1:0];
         rd_valid_ff <= valid_ff[idx_ff[IW-1:0]];
      end
      if (ctrl.eval && rd_act_ff && !cmd_ff && rd_valid_ff && e_addr == ip_ff
          && !hit_ff) begin
         hit_data_ff <= rd_data_ff;
         hit_idx_ff <= rd_idx_ff;
      end
      if (ctrl.eval && rd_act_ff && !rd_valid_ff && !free_found_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      // judgment, registered for use by commit and finish
      new_last_ff <= now_ff;
      new_el_ff <= new_el_in;
      new_cnt_ff <= new_cnt_in;
      new_dis_ff <= new_dis_in;
      full_ff <= full_in;
      verdict_ff <= verdict_in;
      if (ctrl.commit && !cmd_ff) begin
         if (hit_ff && !h_dis) begin
            mem[hit_idx_ff] <= {ip_ff, new_last_ff, new_el_ff, new_cnt_ff, new_dis_ff};
         end else if (!hit_ff && free_found_ff) begin
            mem[free_idx_ff] <= {ip_ff, new_last_ff, new_el_ff, new_cnt_ff, new_dis_ff};
         end
      end
      if (ctrl.finish) begin
         rsp_verdict_ff <= priv_ff && !cmd_ff ? psfrl_pkg::V_ALLOW : verdict_ff;
         rsp_full_ff <= !cmd_ff && !priv_ff && full_ff;
         rsp_removed_ff <= cmd_ff ? removed_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < psfrl_pkg::ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
         idx_ff <= '0;
         rd_act_ff <= 1'b0;
         hit_ff <= 1'b0;
         free_found_ff <= 1'b0;
         removed_ff <= '0;
      end else begin
         rd_act_ff <= ctrl.scan;
         if (ctrl.clear_scan) begin
            idx_ff <= '0;
            hit_ff <= 1'b0;
            free_found_ff <= 1'b0;
            removed_ff <= '0;
         end else if (ctrl.scan) begin
            idx_ff <= idx_ff + psfrl_pkg::CNT_W'(1);
         end
         if (ctrl.eval && rd_act_ff) begin
            if (cmd_ff) begin
               if (rd_valid_ff && expired) begin
                  valid_ff[rd_idx_ff] <= 1'b0;
                  if (removed_ff != psfrl_pkg::REMOVED_MAX) begin
                     removed_ff <= removed_ff + psfrl_pkg::REMOVED_W'(1);
                  end
               end
            end else begin
               if (rd_valid_ff && e_addr == ip_ff) begin
                  hit_ff <= 1'b1;
               end
               if (!rd_valid_ff) begin
                  free_found_ff <= 1'b1;
               end
            end
         end
         if (ctrl.commit && !cmd_ff && !hit_ff && free_found_ff) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
      end
   end

   assign rsp_verdict = rsp_verdict_ff;
   assign rsp_table_full = rsp_full_ff;
   assign rsp_removed_count = rsp_removed_ff;
endmodule

// File: hw/rtl/per_source_flood_rate_limiter_top.sv
// Per-source flood rate limiter: one result per request. A request is
// handled by a scan of the single-port address table, one entry per cycle;
// a privileged action skips the scan and goes straight to the result.
// A sweep walks the full table. Requests are taken one at a time; the next
// request is accepted while the previous result waits in its output register.
`timescale 1ns / 1ps
module per_source_flood_rate_limiter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [psfrl_pkg::ADDR_W-1:0]        req_client_ip,
   input  logic [psfrl_pkg::TIME_W-1:0]        req_now_ms,
   input  logic                                req_privileged,
   input  logic [psfrl_pkg::WIN_W-1:0]         req_idle_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_verdict,
   output logic                                rsp_table_full,
   output logic [psfrl_pkg::REMOVED_W-1:0]     rsp_removed_count,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [psfrl_pkg::PADDR_W-1:0]       csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   psfrl_pkg::ctrl_type                  ctrl;
   psfrl_pkg::stat_type                  stat;
   logic [psfrl_pkg::LIMIT_W-1:0]        limit_ff;
   logic [psfrl_pkg::WIN_W-1:0]          fast_ff, slow_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= psfrl_pkg::LIMIT_W'(10);
         fast_ff <= psfrl_pkg::WIN_W'(10000);
         slow_ff <= psfrl_pkg::WIN_W'(30000);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr)
            psfrl_pkg::REG_ACTION_LIMIT: limit_ff <= csr_pwdata[psfrl_pkg::LIMIT_W-1:0];
            psfrl_pkg::REG_FAST_WINDOW: fast_ff <= csr_pwdata;
            psfrl_pkg::REG_SLOW_WINDOW: slow_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         psfrl_pkg::REG_ACTION_LIMIT: csr_prdata = {26'd0, limit_ff};
         psfrl_pkg::REG_FAST_WINDOW: csr_prdata = fast_ff;
         psfrl_pkg::REG_SLOW_WINDOW: csr_prdata = slow_ff;
         default: csr_prdata = '0;
      endcase
   end

   psfrl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .stat(stat), .ctrl(ctrl)
   );

   psfrl_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_command(req_command), .req_client_ip(req_client_ip),
      .req_now_ms(req_now_ms), .req_privileged(req_privileged),
      .req_idle_ms(req_idle_ms),
      .action_limit(limit_ff), .fast_window_ms(fast_ff), .slow_window_ms(slow_ff),
      .rsp_verdict(rsp_verdict), .rsp_table_full(rsp_table_full),
      .rsp_removed_count(rsp_removed_count)
   );
endmodule
